// ===== design/rolling_pair_correlation_core_assert.svh =====
// Assertion macros for the rolling pair correlation core.
`ifndef ROLLING_PAIR_CORRELATION_CORE_ASSERT_SVH
`define ROLLING_PAIR_CORRELATION_CORE_ASSERT_SVH

// The condition implies the consequence in the same cycle.
`define RPC_ASSERT_NOW(label, cond, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
    else $error(msg);

// The condition implies the consequence in the next cycle.
`define RPC_ASSERT_NEXT(label, cond, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/rpc_pkg.sv =====
// Shared constants for the rolling pair correlation block.
`timescale 1ns / 1ps
package rpc_pkg;
  localparam int CFG_W = 11;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam logic REG_WINDOW_LENGTH = 1'b0;
  localparam logic REG_MIN_OBS = 1'b1;
  localparam logic [CFG_W-1:0] WLEN_RESET = 11'd20;
  localparam logic [CFG_W-1:0] MINOBS_RESET = 11'd10;
  localparam int CORR_W = 16;
  localparam int BETA_W = 32;
  localparam int R2_W = 15;
  localparam int OBS_W = 11;
  localparam int ACC_W = 64;
  localparam int Q14_ONE = 16384;
endpackage

// ===== design/rpc_ifs.sv =====
// Valid/ready channel interfaces for sample pairs and statistics words.
`timescale 1ns / 1ps
interface rpc_in_if #(parameter int SAMPLE_BITS = 16) ();
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] x_sample;
  logic signed [SAMPLE_BITS-1:0] y_sample;
  logic                          pair_valid;
  modport source (output valid, x_sample, y_sample, pair_valid, input ready);
  modport sink (input valid, x_sample, y_sample, pair_valid, output ready);
endinterface

interface rpc_out_if ();
  logic                                valid;
  logic                                ready;
  logic signed [rpc_pkg::CORR_W-1:0]   correlation;
  logic signed [rpc_pkg::BETA_W-1:0]   beta_slope;
  logic        [rpc_pkg::R2_W-1:0]     r_squared;
  logic        [rpc_pkg::OBS_W-1:0]    observation_count;
  logic                                window_full;
  logic                                stats_valid;
  modport source (output valid, correlation, beta_slope, r_squared, observation_count,
                  window_full, stats_valid, input ready);
  modport sink (input valid, correlation, beta_slope, r_squared, observation_count,
                window_full, stats_valid, output ready);
endinterface

// ===== design/rpc_hist.sv =====
// Sample history memory with one write port and one registered read port.
`timescale 1ns / 1ps
module rpc_hist #(
  parameter int DEPTH = 1024,
  parameter int IDX_W = 10,
  parameter int DW = 33
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [IDX_W-1:0] wr_addr,
  input  logic [DW-1:0]    wr_data,
  input  logic             rd_en,
  input  logic [IDX_W-1:0] rd_addr,
  output logic [DW-1:0]    rd_data
);
  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;
endmodule

// ===== design/rpc_mul.sv =====
// Shared 64 by 64 multiplier built from four registered 32 by 32 partial products.
`timescale 1ns / 1ps
module rpc_mul (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            go,
  input  logic [rpc_pkg::ACC_W-1:0]       op_a,
  input  logic [rpc_pkg::ACC_W-1:0]       op_b,
  output logic                            done,
  output logic [2*rpc_pkg::ACC_W-1:0]     prod
);
  localparam int HW = rpc_pkg::ACC_W / 2;

  logic [rpc_pkg::ACC_W-1:0]   a_r, b_r;
  logic [2:0]                  idx_r;
  logic                        busy_r;
  logic [rpc_pkg::ACC_W-1:0]   pp_r;
  logic [1:0]                  sh_r;
  logic                        pp_vld_r;
  logic [2*rpc_pkg::ACC_W-1:0] acc_r;
  logic                        done_r;
  logic [HW-1:0]               a_half, b_half;
  logic [2*rpc_pkg::ACC_W-1:0] pp_shifted;

  always_comb begin
    a_half = idx_r[1] ? a_r[rpc_pkg::ACC_W-1:HW] : a_r[HW-1:0];
    b_half = idx_r[0] ? b_r[rpc_pkg::ACC_W-1:HW] : b_r[HW-1:0];
    pp_shifted = (2*rpc_pkg::ACC_W)'(pp_r) << {sh_r, 5'd0};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r   <= 1'b0;
      pp_vld_r <= 1'b0;
      done_r   <= 1'b0;
      idx_r    <= '0;
    end else begin
      done_r <= 1'b0;
      if (go) begin
        a_r      <= op_a;
        b_r      <= op_b;
        acc_r    <= '0;
        idx_r    <= '0;
        busy_r   <= 1'b1;
        pp_vld_r <= 1'b0;
      end else if (busy_r) begin
        if (idx_r != 3'd4) begin
          pp_r     <= a_half * b_half;
          sh_r     <= 2'(idx_r[1]) + 2'(idx_r[0]);
          pp_vld_r <= 1'b1;
          idx_r    <= idx_r + 3'd1;
        end else begin
          pp_vld_r <= 1'b0;
          busy_r   <= 1'b0;
          done_r   <= 1'b1;
        end
        if (pp_vld_r) begin
          acc_r <= acc_r + pp_shifted;
        end
      end
    end
  end

  assign done = done_r;
  assign prod = acc_r;
endmodule

// ===== design/rpc_div.sv =====
// Restoring divider that produces one quotient bit per cycle.
`timescale 1ns / 1ps
module rpc_div #(
  parameter int W = 64,
  parameter int STEPS = 33
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             go,
  input  logic [W-1:0]     rem_init,
  input  logic [W-1:0]     divisor,
  input  logic [STEPS-1:0] dividend_bits,
  output logic             busy,
  output logic [STEPS-1:0] quot
);
  localparam int CW = $clog2(STEPS + 1);

  logic [W-1:0]     rem_r, dvs_r;
  logic [STEPS-1:0] bits_r, quot_r;
  logic [CW-1:0]    cnt_r;
  logic             busy_r;
  logic [W:0]       trial;
  logic [W:0]       diff;
  logic             ge;

  always_comb begin
    trial = {rem_r, bits_r[STEPS-1]};
    diff  = trial - {1'b0, dvs_r};
    ge    = trial >= {1'b0, dvs_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (go) begin
      rem_r  <= rem_init;
      dvs_r  <= divisor;
      bits_r <= dividend_bits;
      quot_r <= '0;
      cnt_r  <= '0;
      busy_r <= 1'b1;
    end else if (busy_r) begin
      rem_r  <= ge ? diff[W-1:0] : trial[W-1:0];
      bits_r <= {bits_r[STEPS-2:0], 1'b0};
      quot_r <= {quot_r[STEPS-2:0], ge};
      cnt_r  <= cnt_r + CW'(1);
      if (cnt_r == CW'(STEPS - 1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  assign busy = busy_r;
  assign quot = quot_r;
endmodule

// ===== design/rolling_pair_correlation_core.sv =====
// Top level of the rolling pair correlation block: sequencer, running sums and APB registers.
//
// The block takes one word of two signed samples and a pair-valid flag on in_if, keeps the
// last window_length pairs in a history memory, and returns one statistics word on out_if
// for every input word. The word always carries the full flag, and the valid count once the
// window is full; once the window is full, enough pairs are valid and both variances are
// positive, it also carries the correlation (Q2.14), the beta slope (Q16.16) and r squared
// (Q1.14). One word is processed at a time. For a word with statistics the shared 64-bit
// multiplier runs up to fourteen times, then two bit-serial dividers run side by side and a
// 16-step square root follows. The result then moves to an output register, so the next
// word is taken while the previous result still waits for out_if.ready; a stalled receiver
// holds the block only once a second result is ready.
// Registers are written over APB: window_length at 0x0 and min_observations at 0x4.
// Writing window_length restarts the window. Reset restores both registers to their
// defaults and empties the window; the history memory itself is never cleared.
`timescale 1ns / 1ps
`include "rolling_pair_correlation_core_assert.svh"
module rolling_pair_correlation_core #(
  parameter int WINDOW_MAX = 1024,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  rpc_in_if.sink                            in_if,
  rpc_out_if.source                         out_if,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [rpc_pkg::CFG_ADDR_W-1:0]    paddr,
  input  logic [rpc_pkg::CFG_DATA_W-1:0]    pwdata,
  output logic [rpc_pkg::CFG_DATA_W-1:0]    prdata,
  output logic                              pready
);
  localparam int IDX_W = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int CNT_W = $clog2(WINDOW_MAX + 1);
  localparam int LW = (CNT_W > rpc_pkg::CFG_W) ? CNT_W : rpc_pkg::CFG_W;
  localparam int S1_W = (SAMPLE_BITS + CNT_W > 64) ? 64 : SAMPLE_BITS + CNT_W;
  localparam int S2_W = (2 * SAMPLE_BITS + CNT_W > 64) ? 64 : 2 * SAMPLE_BITS + CNT_W;
  localparam int ENT_W = 2 * SAMPLE_BITS + 1;
  localparam int AW = rpc_pkg::ACC_W;
  localparam int CORR_STEPS = 30;
  localparam int BETA_STEPS = 33;

  typedef enum logic [3:0] {
    S_IDLE, S_DROP, S_ADD, S_MUL, S_POST, S_CHECK, S_DIVGO, S_DIVW, S_SQRT, S_FIN, S_OUT
  } state_t;

  typedef enum logic [3:0] {
    OP_DXX, OP_DYY, OP_DXY, OP_AXX, OP_AYY, OP_AXY,
    OP_NXX, OP_SXX, OP_NYY, OP_SYY, OP_NXY, OP_SXY, OP_PAB, OP_PCC
  } op_t;

  state_t state_r;
  op_t    op_r;

  logic [rpc_pkg::CFG_W-1:0] wlen_r, minobs_r;
  logic [LW-1:0]             items_r;
  logic [IDX_W-1:0]          wpos_r;
  logic [CNT_W-1:0]          vcnt_r;
  logic signed [S1_W-1:0]    sum_x_r, sum_y_r;
  logic signed [S2_W-1:0]    sum_xx_r, sum_yy_r, sum_xy_r;

  logic signed [SAMPLE_BITS-1:0] xs_r, ys_r;
  logic                          pv_r, drop_r, full_r;

  logic [AW-1:0]   a_r, b_r, c_r, mag_r;
  logic            neg_r, fsat_r, q0_r, bsat_r;
  logic [2*AW-1:0] p_r, q_r;
  logic [30:0]     f_r;
  logic [15:0]     root_r;
  logic [3:0]      bit_r;
  logic            mul_go_r;

  logic signed [rpc_pkg::CORR_W-1:0] res_corr_r, out_corr_r;
  logic signed [rpc_pkg::BETA_W-1:0] res_beta_r, out_beta_r;
  logic [rpc_pkg::R2_W-1:0]          res_r2_r, out_r2_r;
  logic                              res_stats_r, out_stats_r;
  logic [rpc_pkg::OBS_W-1:0]         out_obs_r;
  logic                              out_full_r, out_valid_r;

  logic [LW-1:0]              eff_w, items_inc;
  logic [rpc_pkg::CFG_W-1:0]  min_obs;
  logic [LW:0]                dp_diff;
  logic [IDX_W-1:0]           dp, wpos_inc;
  logic                       in_acc, cfg_wr, out_load;
  logic [ENT_W-1:0]           rd_data;
  logic signed [SAMPLE_BITS-1:0] xd, yd;
  logic                       vd, drop_en;
  logic [AW-1:0]              mul_a, mul_b;
  logic                       mul_done;
  logic [2*AW-1:0]            mul_prod;
  logic                       div_go, cdiv_busy, bdiv_busy;
  logic [CORR_STEPS-1:0]      cdiv_quot;
  logic [BETA_STEPS-1:0]      bdiv_quot;
  logic [15:0]                cand;
  logic [31:0]                cand_sq;
  logic [16:0]                k_sum, g_sum;
  logic [15:0]                k_val, g_val;
  logic [rpc_pkg::R2_W-1:0]   k_cap, r2_cap;
  logic [BETA_STEPS:0]        d_sum;
  logic [BETA_STEPS-1:0]      bm;
  logic [BETA_STEPS-1:0]      bm_cap;
  logic                       a_ok, b_ok;

  always_comb begin
    eff_w = LW'(wlen_r);
    if (wlen_r == '0) begin
      eff_w = LW'(1);
    end else if (LW'(wlen_r) > LW'(WINDOW_MAX)) begin
      eff_w = LW'(WINDOW_MAX);
    end
    min_obs   = (minobs_r == '0) ? rpc_pkg::CFG_W'(1) : minobs_r;
    items_inc = (items_r < eff_w) ? items_r + LW'(1) : items_r;
    dp_diff   = (LW + 1)'(wpos_r) - (LW + 1)'(eff_w);
    if (dp_diff[LW]) begin
      dp_diff = dp_diff + (LW + 1)'(WINDOW_MAX);
    end
    dp       = dp_diff[IDX_W-1:0];
    wpos_inc = (wpos_r == IDX_W'(WINDOW_MAX - 1)) ? '0 : wpos_r + IDX_W'(1);
  end

  assign in_acc   = in_if.valid && in_if.ready;
  assign cfg_wr   = psel && penable && pwrite && pready;
  assign out_load = (state_r == S_OUT) && (!out_valid_r || out_if.ready);
  assign div_go   = (state_r == S_DIVGO);

  assign xd      = rd_data[SAMPLE_BITS-1:0];
  assign yd      = rd_data[2*SAMPLE_BITS-1:SAMPLE_BITS];
  assign vd      = rd_data[2*SAMPLE_BITS];
  assign drop_en = drop_r && vd && (vcnt_r != '0);

  rpc_hist #(.DEPTH(WINDOW_MAX), .IDX_W(IDX_W), .DW(ENT_W)) u_hist (
    .clk     (clk),
    .wr_en   (in_acc),
    .wr_addr (wpos_r),
    .wr_data ({in_if.pair_valid, in_if.y_sample, in_if.x_sample}),
    .rd_en   (in_acc),
    .rd_addr (dp),
    .rd_data (rd_data)
  );

  always_comb begin
    mul_a = AW'($signed(xd));
    mul_b = AW'($signed(xd));
    case (op_r)
      OP_DXX: begin mul_a = AW'($signed(xd)); mul_b = AW'($signed(xd)); end
      OP_DYY: begin mul_a = AW'($signed(yd)); mul_b = AW'($signed(yd)); end
      OP_DXY: begin mul_a = AW'($signed(xd)); mul_b = AW'($signed(yd)); end
      OP_AXX: begin mul_a = AW'($signed(xs_r)); mul_b = AW'($signed(xs_r)); end
      OP_AYY: begin mul_a = AW'($signed(ys_r)); mul_b = AW'($signed(ys_r)); end
      OP_AXY: begin mul_a = AW'($signed(xs_r)); mul_b = AW'($signed(ys_r)); end
      OP_NXX: begin mul_a = AW'(vcnt_r); mul_b = AW'(sum_xx_r); end
      OP_SXX: begin mul_a = AW'(sum_x_r); mul_b = AW'(sum_x_r); end
      OP_NYY: begin mul_a = AW'(vcnt_r); mul_b = AW'(sum_yy_r); end
      OP_SYY: begin mul_a = AW'(sum_y_r); mul_b = AW'(sum_y_r); end
      OP_NXY: begin mul_a = AW'(vcnt_r); mul_b = AW'(sum_xy_r); end
      OP_SXY: begin mul_a = AW'(sum_x_r); mul_b = AW'(sum_y_r); end
      OP_PAB: begin mul_a = a_r; mul_b = b_r; end
      OP_PCC: begin mul_a = mag_r; mul_b = mag_r; end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  rpc_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .go    (mul_go_r),
    .op_a  (mul_a),
    .op_b  (mul_b),
    .done  (mul_done),
    .prod  (mul_prod)
  );

  rpc_div #(.W(2 * AW), .STEPS(CORR_STEPS)) u_corr_div (
    .clk           (clk),
    .rst_n         (rst_n),
    .go            (div_go),
    .rem_init      ((q_r == p_r) ? '0 : q_r),
    .divisor       (p_r),
    .dividend_bits ('0),
    .busy          (cdiv_busy),
    .quot          (cdiv_quot)
  );

  rpc_div #(.W(AW), .STEPS(BETA_STEPS)) u_beta_div (
    .clk           (clk),
    .rst_n         (rst_n),
    .go            (div_go),
    .rem_init      (mag_r >> 16),
    .divisor       (a_r),
    .dividend_bits ({mag_r[15:0], 17'd0}),
    .busy          (bdiv_busy),
    .quot          (bdiv_quot)
  );

  always_comb begin
    a_ok    = (a_r != '0) && !a_r[AW-1];
    b_ok    = (b_r != '0) && !b_r[AW-1];
    cand    = root_r | (16'd1 << bit_r);
    cand_sq = cand * cand;
    k_sum   = 17'(root_r) + 17'd1;
    k_val   = k_sum[16:1];
    k_cap   = (k_val > 16'(rpc_pkg::Q14_ONE)) ? rpc_pkg::R2_W'(rpc_pkg::Q14_ONE)
                                              : k_val[rpc_pkg::R2_W-1:0];
    g_sum   = 17'(f_r[30:15]) + 17'd1;
    g_val   = g_sum[16:1];
    r2_cap  = (g_val > 16'(rpc_pkg::Q14_ONE)) ? rpc_pkg::R2_W'(rpc_pkg::Q14_ONE)
                                              : g_val[rpc_pkg::R2_W-1:0];
    d_sum   = (BETA_STEPS + 1)'(bdiv_quot) + (BETA_STEPS + 1)'(1);
    bm      = bsat_r ? (BETA_STEPS'(1) << 32) : d_sum[BETA_STEPS:1];
    if (neg_r) begin
      bm_cap = (bm > BETA_STEPS'(33'h080000000)) ? BETA_STEPS'(33'h080000000) : bm;
    end else begin
      bm_cap = (bm > BETA_STEPS'(33'h07FFFFFFF)) ? BETA_STEPS'(33'h07FFFFFFF) : bm;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      op_r        <= OP_DXX;
      mul_go_r    <= 1'b0;
      wlen_r      <= rpc_pkg::WLEN_RESET;
      minobs_r    <= rpc_pkg::MINOBS_RESET;
      items_r     <= '0;
      wpos_r      <= '0;
      vcnt_r      <= '0;
      sum_x_r     <= '0;
      sum_y_r     <= '0;
      sum_xx_r    <= '0;
      sum_yy_r    <= '0;
      sum_xy_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      mul_go_r <= 1'b0;
      if (out_valid_r && out_if.ready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_wr) begin
        if (paddr[2] == rpc_pkg::REG_WINDOW_LENGTH) begin
          wlen_r   <= pwdata[rpc_pkg::CFG_W-1:0];
          items_r  <= '0;
          wpos_r   <= '0;
          vcnt_r   <= '0;
          sum_x_r  <= '0;
          sum_y_r  <= '0;
          sum_xx_r <= '0;
          sum_yy_r <= '0;
          sum_xy_r <= '0;
        end else begin
          minobs_r <= pwdata[rpc_pkg::CFG_W-1:0];
        end
      end
      case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            xs_r    <= in_if.x_sample;
            ys_r    <= in_if.y_sample;
            pv_r    <= in_if.pair_valid;
            drop_r  <= items_r >= eff_w;
            full_r  <= items_inc >= eff_w;
            items_r <= items_inc;
            wpos_r  <= wpos_inc;
            state_r <= S_DROP;
          end
        end
        S_DROP: begin
          if (drop_en) begin
            sum_x_r  <= sum_x_r - S1_W'(xd);
            sum_y_r  <= sum_y_r - S1_W'(yd);
            vcnt_r   <= vcnt_r - CNT_W'(1);
            op_r     <= OP_DXX;
            mul_go_r <= 1'b1;
            state_r  <= S_MUL;
          end else begin
            state_r <= S_ADD;
          end
        end
        S_ADD: begin
          if (pv_r) begin
            sum_x_r  <= sum_x_r + S1_W'(xs_r);
            sum_y_r  <= sum_y_r + S1_W'(ys_r);
            vcnt_r   <= vcnt_r + CNT_W'(1);
            op_r     <= OP_AXX;
            mul_go_r <= 1'b1;
            state_r  <= S_MUL;
          end else begin
            state_r <= S_POST;
          end
        end
        S_MUL: begin
          if (mul_done) begin
            mul_go_r <= 1'b1;
            case (op_r)
              OP_DXX: begin sum_xx_r <= sum_xx_r - S2_W'(mul_prod); op_r <= OP_DYY; end
              OP_DYY: begin sum_yy_r <= sum_yy_r - S2_W'(mul_prod); op_r <= OP_DXY; end
              OP_DXY: begin
                sum_xy_r <= sum_xy_r - S2_W'(mul_prod);
                mul_go_r <= 1'b0;
                state_r  <= S_ADD;
              end
              OP_AXX: begin sum_xx_r <= sum_xx_r + S2_W'(mul_prod); op_r <= OP_AYY; end
              OP_AYY: begin sum_yy_r <= sum_yy_r + S2_W'(mul_prod); op_r <= OP_AXY; end
              OP_AXY: begin
                sum_xy_r <= sum_xy_r + S2_W'(mul_prod);
                mul_go_r <= 1'b0;
                state_r  <= S_POST;
              end
              OP_NXX: begin a_r <= mul_prod[AW-1:0]; op_r <= OP_SXX; end
              OP_SXX: begin a_r <= a_r - mul_prod[AW-1:0]; op_r <= OP_NYY; end
              OP_NYY: begin b_r <= mul_prod[AW-1:0]; op_r <= OP_SYY; end
              OP_SYY: begin b_r <= b_r - mul_prod[AW-1:0]; op_r <= OP_NXY; end
              OP_NXY: begin c_r <= mul_prod[AW-1:0]; op_r <= OP_SXY; end
              OP_SXY: begin
                c_r      <= c_r - mul_prod[AW-1:0];
                mul_go_r <= 1'b0;
                state_r  <= S_CHECK;
              end
              OP_PAB: begin p_r <= mul_prod; op_r <= OP_PCC; end
              OP_PCC: begin
                q_r      <= mul_prod;
                mul_go_r <= 1'b0;
                state_r  <= S_DIVGO;
              end
              default: begin
                mul_go_r <= 1'b0;
                state_r  <= S_IDLE;
              end
            endcase
          end
        end
        S_POST: begin
          if (full_r && (LW'(vcnt_r) >= LW'(min_obs))) begin
            op_r     <= OP_NXX;
            mul_go_r <= 1'b1;
            state_r  <= S_MUL;
          end else begin
            res_corr_r  <= '0;
            res_beta_r  <= '0;
            res_r2_r    <= '0;
            res_stats_r <= 1'b0;
            state_r     <= S_OUT;
          end
        end
        S_CHECK: begin
          if (a_ok && b_ok) begin
            neg_r    <= c_r[AW-1];
            mag_r    <= c_r[AW-1] ? AW'(0) - c_r : c_r;
            op_r     <= OP_PAB;
            mul_go_r <= 1'b1;
            state_r  <= S_MUL;
          end else begin
            res_corr_r  <= '0;
            res_beta_r  <= '0;
            res_r2_r    <= '0;
            res_stats_r <= 1'b0;
            state_r     <= S_OUT;
          end
        end
        S_DIVGO: begin
          fsat_r  <= q_r > p_r;
          q0_r    <= q_r == p_r;
          bsat_r  <= {16'd0, mag_r} >= {a_r, 16'd0};
          state_r <= S_DIVW;
        end
        S_DIVW: begin
          if (!cdiv_busy && !bdiv_busy) begin
            f_r     <= fsat_r ? 31'h7FFFFFFF : {q0_r, cdiv_quot};
            root_r  <= '0;
            bit_r   <= 4'd15;
            state_r <= S_SQRT;
          end
        end
        S_SQRT: begin
          if (cand_sq <= 32'(f_r)) begin
            root_r <= cand;
          end
          if (bit_r == 4'd0) begin
            state_r <= S_FIN;
          end else begin
            bit_r <= bit_r - 4'd1;
          end
        end
        S_FIN: begin
          res_corr_r  <= neg_r ? -rpc_pkg::CORR_W'(k_cap) : rpc_pkg::CORR_W'(k_cap);
          res_r2_r    <= r2_cap;
          res_beta_r  <= neg_r ? rpc_pkg::BETA_W'(BETA_STEPS'(0) - bm_cap)
                               : rpc_pkg::BETA_W'(bm_cap);
          res_stats_r <= 1'b1;
          state_r     <= S_OUT;
        end
        S_OUT: begin
          if (out_load) begin
            out_corr_r  <= res_corr_r;
            out_beta_r  <= res_beta_r;
            out_r2_r    <= res_r2_r;
            out_stats_r <= res_stats_r;
            out_obs_r   <= full_r ? rpc_pkg::OBS_W'(vcnt_r) : '0;
            out_full_r  <= full_r;
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign in_if.ready              = (state_r == S_IDLE);
  assign out_if.valid             = out_valid_r;
  assign out_if.correlation       = out_corr_r;
  assign out_if.beta_slope        = out_beta_r;
  assign out_if.r_squared         = out_r2_r;
  assign out_if.observation_count = out_obs_r;
  assign out_if.window_full       = out_full_r;
  assign out_if.stats_valid       = out_stats_r;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == rpc_pkg::REG_MIN_OBS)
                  ? rpc_pkg::CFG_DATA_W'(minobs_r) : rpc_pkg::CFG_DATA_W'(wlen_r);

  `RPC_ASSERT_NOW(a_mul_idle_on_accept, in_acc, !mul_done && !mul_go_r,
                  "Input word accepted while the multiplier is working.")
  `RPC_ASSERT_NOW(a_count_in_window, 1'b1, LW'(vcnt_r) <= eff_w,
                  "Valid count exceeds the window length.")
  `RPC_ASSERT_NEXT(a_stats_need_full, out_load && res_stats_r,
                   out_if.window_full && out_if.valid,
                   "Statistics reported before the window is full.")
  `RPC_ASSERT_NOW(a_corr_range, out_if.valid,
                  ($signed(out_if.correlation) <= 16'sd16384) &&
                  ($signed(out_if.correlation) >= -16'sd16384) &&
                  (out_if.r_squared <= 15'd16384),
                  "Correlation or r squared out of range.")
endmodule
